FILE: rtl/core/msxbm_pkg.sv
// Shared types, constants and default-mapping functions for the cartridge bank mapper.
// No dependencies; imported by every module in rtl/core.
package msxbm_pkg;

	localparam int PageCount = 8;
	localparam int PageW     = 3;
	localparam int SegW      = 9;
	localparam int OffW      = 13;
	localparam int MemAddrW  = SegW + OffW;

	typedef logic [PageW-1:0] page_t;
	typedef logic [SegW-1:0]  seg_t;

	typedef enum logic [2:0] {
		MT_DISABLED = 3'd0,
		MT_RAM      = 3'd1,
		MT_LINEAR   = 3'd2,
		MT_MIRROR32 = 3'd3,
		MT_KON      = 3'd4,
		MT_KONZ     = 3'd5,
		MT_BANK8    = 3'd6,
		MT_BANK16   = 3'd7
	} mapper_type_t;

	// Up to two page registers written by one bank transaction.
	typedef struct packed {
		logic  en_a;
		page_t idx_a;
		seg_t  seg_a;
		logic  en_b;
		page_t idx_b;
		seg_t  seg_b;
	} bank_upd_t;

	typedef struct packed {
		logic                respond;
		logic                target_ram;
		logic [MemAddrW-1:0] mem_address;
		logic                store_byte;
		logic                bank_updated;
	} result_t;

	function automatic logic default_valid(mapper_type_t mt, page_t i);
		logic v;
		v = 1'b0;
		case (mt)
			MT_RAM, MT_LINEAR, MT_MIRROR32, MT_BANK8, MT_BANK16: v = 1'b1;
			MT_KON, MT_KONZ: v = (i >= 3'd2) && (i <= 3'd5);
			default: v = 1'b0;
		endcase
		return v;
	endfunction

	function automatic seg_t default_seg(mapper_type_t mt, page_t i);
		seg_t s;
		s = '0;
		case (mt)
			MT_RAM, MT_LINEAR: s = {{(SegW-PageW){1'b0}}, i};
			MT_MIRROR32:       s = {{(SegW-2){1'b0}}, i[1:0] + 2'd2};
			MT_KON, MT_KONZ: begin
				if ((i >= 3'd2) && (i <= 3'd5))
					s = {{(SegW-2){1'b0}}, i[1:0] - 2'd2};
			end
			MT_BANK16:         s = {{(SegW-1){1'b0}}, i[0]};
			default:           s = '0;
		endcase
		return s;
	endfunction

endpackage

FILE: rtl/core/msx_cartridge_bank_mapper.sv
// Bank mapper for a 64 KiB cartridge slot: eight 8 KiB pages, several mapper types.
// An accepted input transaction passes the input register, then the result register.
// Throughput: one transaction per cycle while m_tready takes results. The page-register
// lookup sits between the two registers; bank writes commit as the result registers.
// Reset (arst_n low): mapper type disabled, all pages invalid, both pipeline stages empty.
// Depends on msxbm_pkg, msxbm_page_table, msxbm_decode.
module msx_cartridge_bank_mapper
	import msxbm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// configuration: mapper_type
	input  logic        cfg_we,
	input  logic [2:0]  cfg_wdata,
	// input transactions
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // [15:0] address, [23:16] data
	input  logic        s_tuser,   // [0] action (0 read, 1 write)
	// result transactions
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata    // [0] respond, [1] target_ram, [23:2] mem_address,
	                               // [24] store_byte, [25] bank_updated, [31:26] zero
);

	// Stage 1: captured bus access.
	logic        valid_s1;
	logic        action_s1;
	logic [15:0] address_s1;
	logic [7:0]  data_s1;

	// Stage 2: result register.
	logic        valid_s2;
	result_t     result_s2;

	mapper_type_t mapper_type;
	seg_t         page_seg [PageCount];
	logic         page_valid [PageCount];
	result_t      result;
	bank_upd_t    upd;
	logic         advance;
	logic         s_accept;

	// Move stage 1 forward whenever the result register is free or being drained.
	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || !valid_s2 || m_tready;
	assign s_accept = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	// Payload holds while stage 1 is stalled.
	always_ff @(posedge clk) begin
		if (s_accept) begin
			action_s1  <= s_tuser;
			address_s1 <= s_tdata[15:0];
			data_s1    <= s_tdata[23:16];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= result;
		end
	end

	// Page registers; bank writes commit on the same edge the result registers,
	// so the next access in stage 1 already sees the new mapping.
	msxbm_page_table u_page_table (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.commit      (advance),
		.upd         (upd),
		.mapper_type (mapper_type),
		.page_seg    (page_seg),
		.page_valid  (page_valid)
	);

	msxbm_decode u_decode (
		.mapper_type (mapper_type),
		.page_seg    (page_seg),
		.page_valid  (page_valid),
		.action      (action_s1),
		.address     (address_s1),
		.data        (data_s1),
		.result      (result),
		.upd         (upd)
	);

	assign m_tvalid = valid_s2;
	assign m_tdata  = {6'b0,
	                   result_s2.bank_updated,
	                   result_s2.store_byte,
	                   result_s2.mem_address,
	                   result_s2.target_ram,
	                   result_s2.respond};

endmodule

FILE: rtl/core/msxbm_page_table.sv
// Mapper type register and the eight page registers (segment and valid mark).
// Depends on msxbm_pkg.
module msxbm_page_table
	import msxbm_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [2:0]   cfg_wdata,
	input  logic         commit,
	input  bank_upd_t    upd,
	output mapper_type_t mapper_type,
	output seg_t         page_seg [PageCount],
	output logic         page_valid [PageCount]
);

	mapper_type_t type_q;
	seg_t         seg_q [PageCount];
	logic         valid_q [PageCount];
	logic         load;

	assign load = cfg_we && (mapper_type_t'(cfg_wdata) != type_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			type_q <= MT_DISABLED;
		end else if (load) begin
			type_q <= mapper_type_t'(cfg_wdata);
		end
	end

	// Reset state is the disabled type's defaults: all invalid, segment zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PageCount; i++) begin
				seg_q[i]   <= '0;
				valid_q[i] <= 1'b0;
			end
		end else if (load) begin
			for (int i = 0; i < PageCount; i++) begin
				seg_q[i]   <= default_seg(mapper_type_t'(cfg_wdata), page_t'(i));
				valid_q[i] <= default_valid(mapper_type_t'(cfg_wdata), page_t'(i));
			end
		end else if (commit) begin
			if (upd.en_a) begin
				seg_q[upd.idx_a]   <= upd.seg_a;
				valid_q[upd.idx_a] <= 1'b1;
			end
			if (upd.en_b) begin
				seg_q[upd.idx_b]   <= upd.seg_b;
				valid_q[upd.idx_b] <= 1'b1;
			end
		end
	end

	assign mapper_type = type_q;
	assign page_seg    = seg_q;
	assign page_valid  = valid_q;

endmodule

FILE: rtl/core/msxbm_decode.sv
// Combinational access decode: page lookup, result fields and bank register updates.
// Depends on msxbm_pkg.
module msxbm_decode
	import msxbm_pkg::*;
(
	input  mapper_type_t mapper_type,
	input  seg_t         page_seg [PageCount],
	input  logic         page_valid [PageCount],
	input  logic         action,
	input  logic [15:0]  address,
	input  logic [7:0]   data,
	output result_t      result,
	output bank_upd_t    upd
);

	page_t           page;
	logic [OffW-1:0] offset;
	seg_t            seg;
	logic            valid;
	seg_t            data_seg;

	assign page     = address[15:13];
	assign offset   = address[OffW-1:0];
	assign seg      = page_seg[page];
	assign valid    = page_valid[page];
	assign data_seg = {1'b0, data};

	always_comb begin
		result = '0;
		upd    = '0;
		if (!action) begin
			if (valid) begin
				result.respond     = 1'b1;
				result.target_ram  = (mapper_type == MT_RAM);
				result.mem_address = {seg, offset};
			end
		end else begin
			unique case (mapper_type)
				MT_RAM: begin
					if (valid) begin
						result.respond     = 1'b1;
						result.target_ram  = 1'b1;
						result.store_byte  = 1'b1;
						result.mem_address = {seg, offset};
					end
				end
				MT_KON: begin
					if ((page >= 3'd2) && (page <= 3'd5)) begin
						upd.en_a            = 1'b1;
						upd.idx_a           = page;
						upd.seg_a           = data_seg;
						result.bank_updated = 1'b1;
					end
				end
				MT_KONZ: begin
					if ((page == 3'd4) || (page == 3'd5)) begin
						upd.en_a            = 1'b1;
						upd.idx_a           = page;
						upd.seg_a           = data_seg;
						result.bank_updated = 1'b1;
					end
				end
				MT_BANK8: begin
					// 0x6000..0x7FFF: address bits 12:11 pick page 2..5
					if (page == 3'd3) begin
						upd.en_a            = 1'b1;
						upd.idx_a           = 3'd2 + {1'b0, address[12:11]};
						upd.seg_a           = data_seg;
						result.bank_updated = 1'b1;
					end
				end
				MT_BANK16: begin
					// address bit 12 picks the pair 2,3 or 4,5
					if (page == 3'd3) begin
						upd.en_a            = 1'b1;
						upd.idx_a           = address[12] ? 3'd4 : 3'd2;
						upd.seg_a           = {data, 1'b0};
						upd.en_b            = 1'b1;
						upd.idx_b           = address[12] ? 3'd5 : 3'd3;
						upd.seg_b           = {data, 1'b1};
						result.bank_updated = 1'b1;
					end
				end
				default: begin
					result = '0;
				end
			endcase
		end
	end

endmodule

FILE: sim/msx_cartridge_bank_mapper_tb.sv
// Self-checking testbench for msx_cartridge_bank_mapper: every bus transaction is mapped by a
// shadow copy of the page table and compared field by field with the result stream.
// Depends on msxbm_pkg and the mapper RTL under rtl/core.
module msx_cartridge_bank_mapper_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import msxbm_pkg::*;

	// One CPU bus access as the sender sees it.
	typedef struct packed {
		logic        write;
		logic [15:0] address;
		logic [7:0]  data;
	} bus_access_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_wdata = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata = '0;   // [15:0] address, [23:16] data
	logic        s_tuser = 1'b0; // [0] action (0 read, 1 write)
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;        // [0] respond, [1] target_ram, [23:2] mem_address,
	                             // [24] store_byte, [25] bank_updated

	// Shadow of the mapper: current type plus one segment and one valid mark per page.
	mapper_type_t type_shadow = MT_DISABLED;
	seg_t         seg_shadow [PageCount];
	logic         valid_shadow [PageCount];

	bus_access_t access_queue [$];     // transactions waiting for the driver
	result_t     expected_results [$]; // mapped results waiting for the monitor

	int item_count = 0;  // accesses accepted by the block
	int error_count = 0;
	int burst_left = 1;
	int gap_left = 0;
	int results_seen = 0;
	int holdoff_left = 0;
	bit holdoff_done = 1'b0;
	int pattern_left = 0;
	logic [15:0] stall_pattern = '1;

	msx_cartridge_bank_mapper i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	initial begin
		foreach (seg_shadow[i]) begin
			seg_shadow[i] = '0;
			valid_shadow[i] = 1'b0;
		end
	end

	task automatic log_error(string msg);
		$display("tb: mismatch at %0t: %s", $realtime, msg);
		error_count++;
	endtask

	function automatic void load_page(page_t pg, seg_t seg);
		seg_shadow[pg] = seg;
		valid_shadow[pg] = 1'b1;
	endfunction

	// Map one accepted transaction through the shadow page table and apply any bank write.
	function automatic result_t map_access(bus_access_t a);
		result_t     r;
		page_t       pg;
		logic [12:0] off;
		logic        hi;
		r = '0;
		pg = a.address[15:13];
		off = a.address[12:0];
		if (!a.write) begin
			if (valid_shadow[pg]) begin
				r.respond = 1'b1;
				r.target_ram = (type_shadow == MT_RAM);
				r.mem_address = {seg_shadow[pg], off};
			end
		end else if (type_shadow == MT_RAM) begin
			// RAM type never touches the bank registers; a write just stores the byte
			if (valid_shadow[pg]) begin
				r.respond = 1'b1;
				r.target_ram = 1'b1;
				r.store_byte = 1'b1;
				r.mem_address = {seg_shadow[pg], off};
			end
		end else if ((type_shadow == MT_KON && pg >= 3'd2 && pg <= 3'd5) ||
		             (type_shadow == MT_KONZ && pg >= 3'd4 && pg <= 3'd5)) begin
			load_page(pg, {1'b0, a.data});
			r.bank_updated = 1'b1;
		end else if (type_shadow == MT_BANK8 && pg == 3'd3) begin
			// 2 KiB windows in 0x6000..0x7FFF pick pages 2..5
			load_page(3'd2 + {1'b0, a.address[12:11]}, {1'b0, a.data});
			r.bank_updated = 1'b1;
		end else if (type_shadow == MT_BANK16 && pg == 3'd3) begin
			// lower half switches pages 2,3, upper half pages 4,5, as one 16 KiB bank
			hi = a.address[12];
			load_page({1'b0, hi, 1'b0} + 3'd2, {a.data, 1'b0});
			load_page({1'b0, hi, 1'b0} + 3'd3, {a.data, 1'b1});
			r.bank_updated = 1'b1;
		end
		item_count++;
		return r;
	endfunction

	// Mostly well-formed traffic: writes aimed at the bank registers of the current type,
	// reads anywhere. The rest is unconstrained noise.
	function automatic bus_access_t random_access(mapper_type_t t);
		bus_access_t a;
		a.write = 1'($urandom_range(0, 1));
		a.address = 16'($urandom);
		a.data = 8'($urandom);
		if (a.write && $urandom_range(0, 9) < 7) begin
			case (t)
				MT_KON:              a.address = 16'($urandom_range(16'h4000, 16'hBFFF));
				MT_KONZ:             a.address = 16'($urandom_range(16'h8000, 16'hBFFF));
				MT_BANK8, MT_BANK16: a.address = 16'($urandom_range(16'h6000, 16'h7FFF));
				default: ;
			endcase
		end
		return a;
	endfunction

	function automatic void push_access(logic write, logic [15:0] address, logic [7:0] data);
		access_queue.push_back('{write: write, address: address, data: data});
	endfunction

	// Write the mapper type while idle; a new value reloads that type's default mapping.
	task automatic set_type(mapper_type_t t);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= t;
		if (t != type_shadow) begin
			type_shadow = t;
			for (int i = 0; i < PageCount; i++) begin
				seg_shadow[i] = '0;
				valid_shadow[i] = 1'b0;
				case (t)
					MT_RAM, MT_LINEAR: load_page(page_t'(i), seg_t'(i));
					MT_MIRROR32:       load_page(page_t'(i), seg_t'((i + 2) % 4));
					MT_KON, MT_KONZ: begin
						if (i >= 2 && i <= 5)
							load_page(page_t'(i), seg_t'(i - 2));
					end
					MT_BANK8:          load_page(page_t'(i), '0);
					MT_BANK16:         load_page(page_t'(i), seg_t'(i % 2));
					default: ;
				endcase
			end
		end
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Wait until every queued transaction is sent and its result checked, then let the
	// two pipeline stages settle.
	task automatic drain();
		while (access_queue.size() != 0 || expected_results.size() != 0)
			@(negedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic void edge_pair();
		push_access(1'b0, 16'h0000, 8'h00);
		push_access(1'b1, 16'hFFFF, 8'hFF);
	endfunction

	// Driver: send in bursts of random length with random gaps, holding each
	// transaction until the block takes it.
	always @(posedge clk) begin
		bus_access_t nxt;
		logic        taken;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			taken = s_tvalid && s_tready;
			if (taken) begin
				expected_results.push_back(map_access(access_queue.pop_front()));
				burst_left--;
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 24);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
				end
			end
			if (s_tvalid && !taken) begin
				// hold the offered transaction
			end else if (gap_left > 0) begin
				gap_left--;
				s_tvalid <= 1'b0;
			end else if (access_queue.size() != 0) begin
				nxt = access_queue[0];
				s_tvalid <= 1'b1;
				s_tdata <= {nxt.data, nxt.address};
				s_tuser <= nxt.write;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Monitor: check each result against the oldest mapped expectation and stall on a
	// rotating random pattern, with one long hold-off so the pipeline backs up.
	always @(posedge clk) begin
		result_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				results_seen++;
				if (expected_results.size() == 0) begin
					log_error($sformatf("result %h with nothing expected", m_tdata));
				end else begin
					want = expected_results.pop_front();
					if (m_tdata[0] !== want.respond)
						log_error($sformatf("respond %b, want %b", m_tdata[0], want.respond));
					if (m_tdata[1] !== want.target_ram)
						log_error($sformatf("target_ram %b, want %b", m_tdata[1],
							want.target_ram));
					if (m_tdata[23:2] !== want.mem_address)
						log_error($sformatf("mem_address %h, want %h", m_tdata[23:2],
							want.mem_address));
					if (m_tdata[24] !== want.store_byte)
						log_error($sformatf("store_byte %b, want %b", m_tdata[24],
							want.store_byte));
					if (m_tdata[25] !== want.bank_updated)
						log_error($sformatf("bank_updated %b, want %b", m_tdata[25],
							want.bank_updated));
				end
			end
			if (holdoff_left > 0) begin
				holdoff_left--;
				m_tready <= 1'b0;
			end else if (!holdoff_done && results_seen >= 400) begin
				holdoff_done = 1'b1;
				holdoff_left = 300;
				m_tready <= 1'b0;
			end else begin
				if (pattern_left == 0) begin
					pattern_left = 16;
					stall_pattern = ($urandom_range(0, 2) == 0) ? '1 : 16'($urandom);
				end
				m_tready <= stall_pattern[0];
				stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
				pattern_left--;
			end
		end
	end

	initial begin
		mapper_type_t t;
		int n;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part: edge accesses for the reset, RAM, linear, mirror and KON types, bank writes read back.
		@(negedge clk);
		edge_pair();
		drain();
		set_type(MT_RAM);
		edge_pair();
		push_access(1'b1, 16'h1234, 8'h5A);
		push_access(1'b0, 16'h1234, 8'h00);
		drain();
		set_type(MT_LINEAR);
		edge_pair();
		drain();
		set_type(MT_MIRROR32);
		edge_pair();
		drain();
		set_type(MT_KON);
		edge_pair();
		push_access(1'b1, 16'h4000, 8'h80);
		push_access(1'b0, 16'h5FFF, 8'h00);
		drain();
		set_type(MT_KONZ);
		push_access(1'b1, 16'h6000, 8'h11);  // page 3 is fixed here: ignored write
		push_access(1'b1, 16'h8000, 8'h7F);
		push_access(1'b0, 16'h8000, 8'h00);
		drain();
		set_type(MT_BANK8);
		push_access(1'b1, 16'h6800, 8'hAA);
		push_access(1'b0, 16'h6000, 8'h00);
		drain();
		set_type(MT_BANK16);
		push_access(1'b1, 16'h7000, 8'hFF);  // top bank: highest memory address
		push_access(1'b0, 16'hBFFF, 8'h00);
		drain();
		// rewrite the same type: the switched banks must survive
		set_type(MT_BANK16);
		push_access(1'b0, 16'hBFFF, 8'h00);
		drain();

		// Random phases: a type per phase, sometimes the current one again.
		while (item_count < 1550) begin
			t = ($urandom_range(0, 3) == 0) ? type_shadow : mapper_type_t'($urandom_range(0, 7));
			set_type(t);
			n = $urandom_range(20, 120);
			@(negedge clk);
			repeat (n) access_queue.push_back(random_access(type_shadow));
			drain();
		end

		repeat (8) @(posedge clk);
		if (error_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	initial begin
		#1_000_000;
		$display("tb: failure");
		$finish;
	end

endmodule
